// ===== rtl/c8_pkg.sv =====
package c8_pkg;

  localparam int MemBytes     = 4096;
  localparam int StackDepth   = 16;
  localparam int ScreenW      = 64;
  localparam int ScreenH      = 32;
  localparam int ProgramStart = 512;
  localparam int FontBytes    = 80;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_ROW   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    AUD_NONE  = 2'd0,
    AUD_START = 2'd1,
    AUD_STOP  = 2'd2
  } audio_e;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_DECODE,
    ST_RET,
    ST_CLS,
    ST_DRAW_RD,
    ST_DRAW_ROW,
    ST_DRAW_WR,
    ST_BCD,
    ST_STORE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_ROW_RD,
    ST_ROW_WAIT,
    ST_DONE
  } state_e;

  function automatic logic [7:0] font_byte(input logic [6:0] a);
    logic [7:0] f [80];
    f = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
          8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
          8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
    font_byte = (a < 7'd80) ? f[a] : 8'h00;
  endfunction

endpackage

// ===== rtl/c8_ram.sv =====
module c8_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/chip8_instruction_core.sv =====
// CHIP-8 core: one command per transfer, one result per command.
// Load and tick go straight to the result; a row read passes ST_ROW_RD and ST_ROW_WAIT;
// an execute waiting for a key goes straight to the result, any other fetches and decodes
// (a draw reads, shifts and writes each row, FX55 writes and FX65 reads each register).
// The byte and frame row memories, each with one read and one write port, bound the rate; one
// command is in flight at a time, the result register frees the input side.
// Reset: a clearing pass over all 4096 bytes loads the font and zeros the memory, and
// the 32 rows of the frame memory are cleared alongside; no input is taken then.
module chip8_instruction_core
  import c8_pkg::*;
#(
  parameter int StackDepthP   = StackDepth,
  parameter int ProgramStartP = ProgramStart
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] cmd, [13:2] load_addr, [21:14] load_data, [37:22] keys_down,
  // [45:38] rand_byte, [50:46] row_select, [55:51] zero
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [11:0] prog_counter, [75:12] row_pixels, [76] drew, [78:77] audio_event,
  // [79] awaiting_key, [80] bad_opcode, [87:81] zero
  output logic [87:0] m_axis_tdata_o
);

  localparam int SpW = $clog2(StackDepthP);

  // Latched command fields
  logic [1:0]  cmd_q;
  logic [11:0] laddr_q;
  logic [7:0]  ldata_q, rnd_q;
  logic [15:0] keys_q;
  logic [4:0]  rsel_q;

  // Architectural state kept in flops
  logic [7:0]  v_q [16];
  logic [11:0] i_q, pc_q;
  logic [11:0] stk_q [StackDepthP];
  logic [SpW-1:0] sp_q;
  logic [7:0]  dt_q, st_q;
  logic        wait_q;
  logic [3:0]  wtgt_q;

  state_e state_q, state_d;
  logic [11:0] clr_q;
  logic [15:0] op_q;
  logic [4:0]  cnt_q;
  logic [63:0] sprite_q;
  logic        drew_q, bad_q;
  logic [1:0]  aud_q;
  logic        obusy_q;

  // Byte memory port
  logic        mwe;
  logic [11:0] mwa, mra;
  logic [7:0]  mwd, mrd;
  // Frame memory port
  logic        fwe;
  logic [4:0]  fwa, fra;
  logic [63:0] fwd, frd;

  c8_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i, .we_i(mwe), .waddr_i(mwa), .wdata_i(mwd), .raddr_i(mra), .rdata_o(mrd));
  c8_ram #(.Width(ScreenW), .Depth(ScreenH)) u_fb (
    .clk_i, .we_i(fwe), .waddr_i(fwa), .wdata_i(fwd), .raddr_i(fra), .rdata_o(frd));

  logic [3:0] ox, oy, on;
  logic [7:0] vx, vy;
  assign ox = op_q[11:8];
  assign oy = op_q[7:4];
  assign on = op_q[3:0];
  assign vx = v_q[ox];
  assign vy = v_q[oy];

  // Sprite origin, held from decode since VF changes during the draw
  logic [5:0] x0_q;
  logic [4:0] y0_q;
  logic [5:0] x0;
  logic [4:0] y0;
  logic [5:0] drow;
  assign x0   = x0_q;
  assign y0   = y0_q;
  assign drow = {1'b0, y0} + {1'b0, cnt_q};

  logic [7:0] bcd_h, bcd_t, bcd_o;
  always_comb begin
    bcd_h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    bcd_t = 8'((16'(vx - 8'(bcd_h * 8'd100)) * 16'd205) >> 11);
    bcd_o = 8'(vx - 8'(bcd_h * 8'd100) - 8'(bcd_t * 8'd10));
  end

  logic in_xfer, out_xfer;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tvalid_o = obusy_q;

  // Decode classes
  logic known;
  always_comb begin
    case (op_q[15:12])
      4'h0:    known = (op_q == 16'h00E0) || (op_q == 16'h00EE);
      4'h8:    known = (on <= 4'h7) || (on == 4'hE);
      4'hE:    known = (op_q[7:0] == 8'h9E) || (op_q[7:0] == 8'hA1);
      4'hF:    known = (op_q[7:0] == 8'h07) || (op_q[7:0] == 8'h0A) ||
                       (op_q[7:0] == 8'h15) || (op_q[7:0] == 8'h18) ||
                       (op_q[7:0] == 8'h1E) || (op_q[7:0] == 8'h29) ||
                       (op_q[7:0] == 8'h33) || (op_q[7:0] == 8'h55) ||
                       (op_q[7:0] == 8'h65);
      default: known = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:     if (clr_q == 12'hFFF) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          case (cmd_e'(s_axis_tdata_i[1:0]))
            CMD_EXEC: state_d = wait_q ? ST_DONE : ST_FETCH_HI;
            CMD_ROW:  state_d = ST_ROW_RD;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_FETCH_HI: state_d = ST_FETCH_LO;
      ST_FETCH_LO: state_d = ST_DECODE;
      ST_DECODE: begin
        state_d = ST_DONE;
        if (known) begin
          case (op_q[15:12])
            4'h0: state_d = (op_q[7:0] == 8'hE0) ? ST_CLS : ST_RET;
            4'hD: state_d = ST_DRAW_RD;
            4'hF: begin
              if (op_q[7:0] == 8'h33) state_d = ST_BCD;
              else if (op_q[7:0] == 8'h55) state_d = ST_STORE;
              else if (op_q[7:0] == 8'h65) state_d = ST_LOAD_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RET:      state_d = ST_DONE;
      ST_CLS:      if (cnt_q == 5'd31) state_d = ST_DONE;
      ST_DRAW_RD: begin
        if ({1'b0, cnt_q} >= {2'b0, on} || drow >= 6'(ScreenH)) state_d = ST_DONE;
        else state_d = ST_DRAW_ROW;
      end
      ST_DRAW_ROW: state_d = ST_DRAW_WR;
      ST_DRAW_WR:  state_d = ST_DRAW_RD;
      ST_BCD:      if (cnt_q == 5'd2) state_d = ST_DONE;
      ST_STORE:    if (cnt_q[3:0] == ox) state_d = ST_DONE;
      ST_LOAD_RD:  state_d = ST_LOAD_WR;
      ST_LOAD_WR:  state_d = (cnt_q[3:0] == ox) ? ST_DONE : ST_LOAD_RD;
      ST_ROW_RD:   state_d = ST_ROW_WAIT;
      ST_ROW_WAIT: state_d = ST_DONE;
      ST_DONE:     if (!obusy_q || out_xfer) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Memory port drive
  logic [63:0] spr_shift;
  always_comb begin
    spr_shift = {mrd, 56'b0} >> x0;
    mwe = 1'b0;
    mwa = laddr_q;
    mwd = ldata_q;
    mra = pc_q;
    fwe = 1'b0;
    fwa = drow[4:0];
    fwd = frd ^ sprite_q;
    fra = drow[4:0];
    case (state_q)
      ST_INIT: begin
        mwe = 1'b1;
        mwa = clr_q;
        mwd = (clr_q < 12'(FontBytes)) ? font_byte(clr_q[6:0]) : 8'h00;
        fwe = 1'b1;
        fwa = clr_q[4:0];
        fwd = '0;
      end
      ST_IDLE:     mra = pc_q;
      ST_FETCH_HI: mra = pc_q + 12'd1;
      ST_DONE:     mwe = (cmd_q == CMD_LOAD) && (state_q != state_d) && 1'b0;
      ST_CLS: begin
        fwe = 1'b1;
        fwa = cnt_q;
        fwd = '0;
      end
      ST_DRAW_RD:  mra = i_q + 12'(cnt_q);
      ST_DRAW_WR:  fwe = 1'b1;
      ST_BCD: begin
        mwe = 1'b1;
        mwa = i_q + 12'(cnt_q);
        mwd = (cnt_q == 5'd0) ? bcd_h : (cnt_q == 5'd1) ? bcd_t : bcd_o;
      end
      ST_STORE: begin
        mwe = 1'b1;
        mwa = i_q + 12'(cnt_q);
        mwd = v_q[cnt_q[3:0]];
      end
      ST_LOAD_RD:  mra = i_q + 12'(cnt_q);
      ST_ROW_RD:   fra = rsel_q;
      default: ;
    endcase
    if (state_q == ST_IDLE && in_xfer && s_axis_tdata_i[1:0] == CMD_LOAD) begin
      mwe = 1'b1;
      mwa = s_axis_tdata_i[13:2];
      mwd = s_axis_tdata_i[21:14];
    end
  end

  logic kdn;
  assign kdn = (vx < 8'd16) && keys_q[vx[3:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      clr_q   <= '0;
      cnt_q   <= '0;
      obusy_q <= 1'b0;
      pc_q    <= 12'(ProgramStartP);
      i_q     <= '0;
      sp_q    <= '0;
      dt_q    <= '0;
      st_q    <= '0;
      wait_q  <= 1'b0;
      wtgt_q  <= '0;
      x0_q    <= '0;
      y0_q    <= '0;
      for (int r = 0; r < 16; r++) v_q[r] <= '0;
      for (int r = 0; r < StackDepthP; r++) stk_q[r] <= '0;
    end else begin
      state_q <= state_d;
      if (out_xfer) obusy_q <= 1'b0;
      case (state_q)
        ST_INIT: clr_q <= clr_q + 12'd1;
        ST_IDLE: begin
          cnt_q  <= '0;
          drew_q <= 1'b0;
          bad_q  <= 1'b0;
          aud_q  <= AUD_NONE;
          sprite_q <= '0;
          if (in_xfer) begin
            cmd_q   <= s_axis_tdata_i[1:0];
            laddr_q <= s_axis_tdata_i[13:2];
            ldata_q <= s_axis_tdata_i[21:14];
            keys_q  <= s_axis_tdata_i[37:22];
            rnd_q   <= s_axis_tdata_i[45:38];
            rsel_q  <= s_axis_tdata_i[50:46];
            if (s_axis_tdata_i[1:0] == CMD_TICK) begin
              if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
              if (st_q != 8'd0) begin
                st_q  <= st_q - 8'd1;
                aud_q <= AUD_START;
              end else begin
                aud_q <= AUD_STOP;
              end
            end
          end
        end
        ST_FETCH_HI: op_q[15:8] <= mrd;
        ST_FETCH_LO: op_q[7:0] <= mrd;
        ST_DECODE: begin
          x0_q <= vx[5:0];
          y0_q <= vy[4:0];
          if (!known) begin
            bad_q <= 1'b1;
            pc_q  <= pc_q + 12'd2;
          end else begin
            case (op_q[15:12])
              4'h0: begin
                if (op_q[7:0] == 8'hE0) begin
                  drew_q <= 1'b1;
                  pc_q   <= pc_q + 12'd2;
                end else begin
                  sp_q <= (sp_q == '0) ? SpW'(StackDepthP - 1) : sp_q - SpW'(1);
                end
              end
              4'h1: pc_q <= op_q[11:0];
              4'h2: begin
                stk_q[sp_q] <= pc_q;
                sp_q <= (32'(sp_q) + 1 >= StackDepthP) ? '0 : sp_q + SpW'(1);
                pc_q <= op_q[11:0];
              end
              4'h3: pc_q <= pc_q + ((vx == op_q[7:0]) ? 12'd4 : 12'd2);
              4'h4: pc_q <= pc_q + ((vx != op_q[7:0]) ? 12'd4 : 12'd2);
              4'h5: pc_q <= pc_q + ((vx == vy) ? 12'd4 : 12'd2);
              4'h6: begin
                v_q[ox] <= op_q[7:0];
                pc_q <= pc_q + 12'd2;
              end
              4'h7: begin
                v_q[ox] <= vx + op_q[7:0];
                pc_q <= pc_q + 12'd2;
              end
              4'h8: begin
                pc_q <= pc_q + 12'd2;
                case (on)
                  4'h0: v_q[ox] <= vy;
                  4'h1: v_q[ox] <= vx | vy;
                  4'h2: v_q[ox] <= vx & vy;
                  4'h3: v_q[ox] <= vx ^ vy;
                  4'h4: begin
                    v_q[15] <= {7'b0, (9'(vx) + 9'(vy)) > 9'd255};
                    v_q[ox] <= vx + vy;
                  end
                  4'h5: begin
                    v_q[15] <= {7'b0, vx > vy};
                    v_q[ox] <= vx - vy;
                  end
                  4'h6: begin
                    v_q[15] <= {7'b0, vx[0]};
                    v_q[ox] <= vx >> 1;
                  end
                  4'h7: begin
                    v_q[15] <= {7'b0, vy > vx};
                    v_q[ox] <= vy - vx;
                  end
                  default: begin
                    v_q[15] <= {7'b0, vx[7]};
                    v_q[ox] <= vx << 1;
                  end
                endcase
              end
              4'h9: pc_q <= pc_q + ((vx != vy) ? 12'd4 : 12'd2);
              4'hA: begin
                i_q  <= op_q[11:0];
                pc_q <= pc_q + 12'd2;
              end
              4'hB: pc_q <= op_q[11:0] + 12'(v_q[0]);
              4'hC: begin
                v_q[ox] <= rnd_q & op_q[7:0];
                pc_q <= pc_q + 12'd2;
              end
              4'hD: begin
                drew_q  <= 1'b1;
                v_q[15] <= '0;
                pc_q    <= pc_q + 12'd2;
              end
              4'hE: begin
                if (op_q[7:0] == 8'h9E) pc_q <= pc_q + (kdn ? 12'd4 : 12'd2);
                else pc_q <= pc_q + (!kdn ? 12'd4 : 12'd2);
              end
              default: begin
                pc_q <= pc_q + 12'd2;
                case (op_q[7:0])
                  8'h07: v_q[ox] <= dt_q;
                  8'h0A: begin
                    wait_q <= 1'b1;
                    wtgt_q <= ox;
                  end
                  8'h15: dt_q <= vx;
                  8'h18: st_q <= vx;
                  8'h1E: i_q <= i_q + 12'(vx);
                  8'h29: i_q <= 12'(11'(vx) * 11'd5);
                  default: ;
                endcase
              end
            endcase
          end
        end
        ST_RET: pc_q <= stk_q[sp_q] + 12'd2;
        ST_CLS: cnt_q <= cnt_q + 5'd1;
        ST_DRAW_ROW: sprite_q <= spr_shift;
        ST_DRAW_WR: begin
          if ((frd & sprite_q) != '0) v_q[15] <= 8'd1;
          cnt_q <= cnt_q + 5'd1;
        end
        ST_BCD:   cnt_q <= cnt_q + 5'd1;
        ST_STORE: cnt_q <= cnt_q + 5'd1;
        ST_LOAD_WR: begin
          v_q[cnt_q[3:0]] <= mrd;
          cnt_q <= cnt_q + 5'd1;
        end
        ST_ROW_WAIT: sprite_q <= frd;
        ST_DONE: begin
          if (state_d == ST_IDLE) begin
            obusy_q <= 1'b1;
          end
        end
        default: ;
      endcase
      // Key wait resolves at the start of the item
      if (state_q == ST_IDLE && in_xfer && s_axis_tdata_i[1:0] == CMD_EXEC && wait_q) begin
        if (|s_axis_tdata_i[37:22]) begin
          wait_q <= 1'b0;
          for (int k = 15; k >= 0; k--) begin
            if (s_axis_tdata_i[22+k]) v_q[wtgt_q] <= 8'(k);
          end
        end
      end
    end
  end

  // Result register
  logic [87:0] res_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && state_d == ST_IDLE) begin
      res_q <= {7'b0, bad_q, wait_q, aud_q, drew_q,
                (cmd_q == CMD_ROW) ? sprite_q : 64'b0, pc_q};
    end
  end
  assign m_axis_tdata_o = res_q;

  // Assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !(state_q == ST_INIT))
    else $error("transfer taken during clear pass");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwe |-> (state_q == ST_INIT || state_q == ST_CLS || state_q == ST_DRAW_WR))
    else $error("frame write outside clear or draw");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=> m_axis_tvalid_o)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped");

endmodule
